// File: hdl/voxel_ray_dda_stepper_assert.svh
// Assertion macros for the checker file of the voxel ray stepper.
`ifndef VOXEL_RAY_DDA_STEPPER_ASSERT_SVH
`define VOXEL_RAY_DDA_STEPPER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define VRDS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define VRDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/vrds_pkg.sv
// ----------------------------------------------------------------------------
// vrds_pkg
// Types, codes and constants shared by the voxel ray stepper modules.
// ----------------------------------------------------------------------------
package vrds_pkg;

	localparam int COORD_BITS_DEF = 16;

	// Request operation codes.
	localparam logic OP_START  = 1'b0;
	localparam logic OP_ANSWER = 1'b1;

	// Result kinds.
	localparam logic [1:0] KIND_QUERY = 2'd0;
	localparam logic [1:0] KIND_HIT   = 2'd1;
	localparam logic [1:0] KIND_MISS  = 2'd2;

	// Axis codes.
	localparam logic [1:0] AXIS_X    = 2'd0;
	localparam logic [1:0] AXIS_Y    = 2'd1;
	localparam logic [1:0] AXIS_Z    = 2'd2;
	localparam logic [1:0] AXIS_NONE = 2'd3;

	localparam logic [31:0] LEN_SAT = 32'hFFFF_FFFF;

	typedef struct packed {
		logic               op;
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic [31:0]        max_distance;
		logic               occupied;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [15:0] voxel_x;
		logic signed [15:0] voxel_y;
		logic signed [15:0] voxel_z;
		logic signed [15:0] back_x;
		logic signed [15:0] back_y;
		logic signed [15:0] back_z;
		logic               back_valid;
	} rsp_t;

	// Top-level control states.
	typedef enum logic {
		ST_IDLE,
		ST_SETUP
	} ctl_state_t;

	// Phases of the setup sequencer.
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SQ,
		PH_SQRT,
		PH_DIV,
		PH_MUL,
		PH_BND
	} setup_phase_t;

endpackage

// File: hdl/vrds_setup.sv
// ----------------------------------------------------------------------------
// vrds_setup
// Iterative ray setup: sum of squared direction components, a bit-pair
// square root, a restoring division per axis and one shared multiplier
// for the squares and the first boundary lengths.
// ----------------------------------------------------------------------------
module vrds_setup (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] dir [3],
	input  logic [15:0]        frac [3],
	output logic               done,
	output logic [31:0]        unit_len [3],
	output logic [31:0]        bnd [3]
);
	import vrds_pkg::*;

	setup_phase_t phase_q, phase_d;
	logic [1:0]   axis_q;
	logic [4:0]   cnt_q;
	logic         done_q;

	logic [15:0]  mag_q [3];
	logic [16:0]  fr_q [3];
	logic [31:0]  acc_q;
	logic [63:0]  n_q;
	logic [63:0]  r_q;
	logic [15:0]  rem_q;
	logic [31:0]  quo_q;
	logic [47:0]  prod_q;
	logic [31:0]  unit_q [3];
	logic [31:0]  bnd_q [3];

	logic [15:0]  mul_a;
	logic [31:0]  mul_b;
	logic [47:0]  mul_p;
	logic [63:0]  sq_bit;
	logic [63:0]  sq_try;
	logic         sq_ge;
	logic [31:0]  len_w;
	logic [16:0]  div_try;
	logic         div_ge;
	logic         last_iter;
	logic         last_axis;

	// Shared multiplier: squares first, then fraction times unit length.
	always_comb begin
		if (phase_q == PH_SQ) begin
			mul_a = mag_q[axis_q];
			mul_b = {16'd0, mag_q[axis_q]};
		end else begin
			mul_a = fr_q[axis_q][15:0];
			mul_b = unit_q[axis_q];
		end
		mul_p = 48'(mul_a) * 48'(mul_b);
	end

	// One square-root step and one division step.
	always_comb begin
		sq_bit  = 64'd1 << {cnt_q, 1'b0};
		sq_try  = r_q + sq_bit;
		sq_ge   = n_q >= sq_try;
		len_w   = r_q[31:0];
		div_try = {rem_q, len_w[cnt_q]};
		div_ge  = div_try >= {1'b0, mag_q[axis_q]};
	end

	assign last_iter = (cnt_q == 5'd0);
	assign last_axis = (axis_q == AXIS_Z);

	// Sequencer next phase.
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (start) phase_d = PH_SQ;
			end
			PH_SQ: begin
				if (last_axis) phase_d = PH_SQRT;
			end
			PH_SQRT: begin
				if (last_iter) phase_d = PH_DIV;
			end
			PH_DIV: begin
				if (last_iter) phase_d = PH_MUL;
			end
			PH_MUL: begin
				phase_d = PH_BND;
			end
			PH_BND: begin
				phase_d = last_axis ? PH_IDLE : PH_DIV;
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	// Phase register and done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q  <= (phase_q == PH_BND) && last_axis;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				if (start) begin
					for (int a = 0; a < 3; a++) begin
						mag_q[a] <= (dir[a] < 0) ? 16'(-dir[a]) : 16'(dir[a]);
						fr_q[a]  <= (dir[a] < 0) ? {1'b0, frac[a]}
							: 17'h10000 - {1'b0, frac[a]};
					end
					acc_q  <= 32'd0;
					axis_q <= AXIS_X;
				end
			end
			PH_SQ: begin
				acc_q <= acc_q + mul_p[31:0];
				if (last_axis) begin
					n_q   <= {acc_q + mul_p[31:0], 32'd0};
					r_q   <= 64'd0;
					cnt_q <= 5'd31;
				end else begin
					axis_q <= axis_q + 2'd1;
				end
			end
			PH_SQRT: begin
				if (sq_ge) begin
					n_q <= n_q - sq_try;
					r_q <= (r_q >> 1) + sq_bit;
				end else begin
					r_q <= r_q >> 1;
				end
				cnt_q <= cnt_q - 5'd1;
				if (last_iter) begin
					axis_q <= AXIS_X;
					rem_q  <= 16'd0;
				end
			end
			PH_DIV: begin
				// A zero divisor makes every quotient bit one, which is saturation.
				rem_q <= div_ge ? 16'(div_try - {1'b0, mag_q[axis_q]}) : div_try[15:0];
				quo_q <= {quo_q[30:0], div_ge};
				cnt_q <= cnt_q - 5'd1;
				if (last_iter) unit_q[axis_q] <= {quo_q[30:0], div_ge};
			end
			PH_MUL: begin
				prod_q <= mul_p;
			end
			PH_BND: begin
				// A whole cell to the boundary is exactly one unit length.
				bnd_q[axis_q] <= fr_q[axis_q][16] ? unit_q[axis_q] : prod_q[47:16];
				if (!last_axis) begin
					axis_q <= axis_q + 2'd1;
					cnt_q  <= 5'd31;
					rem_q  <= 16'd0;
				end
			end
			default: ;
		endcase
	end

	assign done     = done_q;
	assign unit_len = unit_q;
	assign bnd      = bnd_q;

endmodule

// File: hdl/voxel_ray_dda_stepper.sv
// ----------------------------------------------------------------------------
// voxel_ray_dda_stepper
// Fixed-point 3-D voxel traversal: ray setup, occupancy queries and steps.
// ----------------------------------------------------------------------------
//  channel | signals                    | carries
//  cmd     | cmd_valid, cmd_stall, cmd  | start or answer request (cmd_t)
//  rsp     | rsp_valid, rsp_stall, rsp  | query, hit or miss result (rsp_t)
//
// A start request gives its result after a setup sequence: three squares,
// a 32-step square root and, per axis, a 32-step division, a multiply and a
// boundary step share one arithmetic unit, and a registered done pulse signals completion.
// An answer request is handled by one compare tree and one add.
// A request is taken while no setup runs and the result register is empty or
// being drained. Reset clears the control state only; no clearing pass is needed.
// ----------------------------------------------------------------------------
module voxel_ray_dda_stepper #(
	parameter int COORD_BITS = vrds_pkg::COORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  vrds_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output vrds_pkg::rsp_t rsp
);
	import vrds_pkg::*;

	ctl_state_t ctl_q, ctl_d;

	logic [COORD_BITS-1:0] cell_q [3];
	logic [COORD_BITS-1:0] start_q [3];
	logic                  sign_q [3];
	logic [31:0]           bnd_q [3];
	logic [31:0]           limit_q;
	logic [1:0]            last_q;
	logic                  active_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic                  accept;
	logic                  start_go;
	logic                  answer_go;
	logic signed [15:0]    dir_w [3];
	logic [15:0]           frac_w [3];
	logic                  su_done;
	logic [31:0]           su_unit [3];
	logic [31:0]           su_bnd [3];

	logic [1:0]            sel;
	logic [COORD_BITS-1:0] cell_step [3];
	logic [32:0]           bnd_sum;
	logic [31:0]           trav;
	logic                  moved;
	rsp_t                  rsp_step;
	rsp_t                  rsp_hit;
	rsp_t                  rsp_first;

	// Cell coordinate in the 16-bit output format.
	function automatic logic [15:0] cell_out(input logic [COORD_BITS-1:0] c);
		cell_out = 16'(signed'(c));
	endfunction

	// Integer part of a Q16.16 origin, wrapped to the cell width.
	function automatic logic [COORD_BITS-1:0] cell_in(input logic [31:0] org);
		cell_in = COORD_BITS'(32'(signed'(org[31:16])));
	endfunction

	// Request handshake.
	assign cmd_stall = (ctl_q != ST_IDLE) || (rsp_valid_q && rsp_stall);
	assign accept    = cmd_valid && !cmd_stall;
	assign start_go  = accept && (cmd.op == OP_START);
	assign answer_go = accept && (cmd.op == OP_ANSWER) && active_q;

	assign dir_w  = '{cmd.dir_x, cmd.dir_y, cmd.dir_z};
	assign frac_w = '{cmd.origin_x[15:0], cmd.origin_y[15:0], cmd.origin_z[15:0]};

	vrds_setup u_setup (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_go),
		.dir      (dir_w),
		.frac     (frac_w),
		.done     (su_done),
		.unit_len (su_unit),
		.bnd      (su_bnd)
	);

	// Step choice: nearest boundary, ties go to z.
	always_comb begin
		if (bnd_q[0] < bnd_q[1] && bnd_q[0] < bnd_q[2]) sel = AXIS_X;
		else if (bnd_q[1] < bnd_q[0] && bnd_q[1] < bnd_q[2]) sel = AXIS_Y;
		else sel = AXIS_Z;
		for (int a = 0; a < 3; a++) begin
			cell_step[a] = cell_q[a];
		end
		cell_step[sel] = sign_q[sel] ? cell_q[sel] - COORD_BITS'(1)
			: cell_q[sel] + COORD_BITS'(1);
		trav    = bnd_q[sel];
		bnd_sum = {1'b0, bnd_q[sel]} + {1'b0, su_unit[sel]};
	end

	// Result of a step: next query or a miss.
	always_comb begin
		rsp_step = '0;
		if (trav < limit_q) begin
			rsp_step.kind    = KIND_QUERY;
			rsp_step.voxel_x = cell_out(cell_step[0]);
			rsp_step.voxel_y = cell_out(cell_step[1]);
			rsp_step.voxel_z = cell_out(cell_step[2]);
		end else begin
			rsp_step.kind = KIND_MISS;
		end
	end

	// First result of a ray: the start voxel, or a miss for a zero limit.
	always_comb begin
		rsp_first = '0;
		if (limit_q != 32'd0) begin
			rsp_first.kind    = KIND_QUERY;
			rsp_first.voxel_x = cell_out(cell_q[0]);
			rsp_first.voxel_y = cell_out(cell_q[1]);
			rsp_first.voxel_z = cell_out(cell_q[2]);
		end else begin
			rsp_first.kind = KIND_MISS;
		end
	end

	// Result of a hit, with the voxel the ray came from.
	always_comb begin
		logic [COORD_BITS-1:0] bk [3];
		for (int a = 0; a < 3; a++) begin
			bk[a] = cell_q[a];
		end
		moved = (last_q != AXIS_NONE) && ((cell_q[0] != start_q[0]) ||
			(cell_q[1] != start_q[1]) || (cell_q[2] != start_q[2]));
		if (last_q != AXIS_NONE) begin
			bk[last_q] = sign_q[last_q] ? cell_q[last_q] + COORD_BITS'(1)
				: cell_q[last_q] - COORD_BITS'(1);
		end
		rsp_hit         = '0;
		rsp_hit.kind    = KIND_HIT;
		rsp_hit.voxel_x = cell_out(cell_q[0]);
		rsp_hit.voxel_y = cell_out(cell_q[1]);
		rsp_hit.voxel_z = cell_out(cell_q[2]);
		if (moved) begin
			rsp_hit.back_x     = cell_out(bk[0]);
			rsp_hit.back_y     = cell_out(bk[1]);
			rsp_hit.back_z     = cell_out(bk[2]);
			rsp_hit.back_valid = 1'b1;
		end
	end

	// Control next state.
	always_comb begin
		ctl_d = ctl_q;
		unique case (ctl_q)
			ST_IDLE:  if (start_go) ctl_d = ST_SETUP;
			ST_SETUP: if (su_done) ctl_d = ST_IDLE;
			default:  ctl_d = ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q       <= ST_IDLE;
			active_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			ctl_q <= ctl_d;
			if (start_go) begin
				active_q <= 1'b0;
			end else if (ctl_q == ST_SETUP && su_done) begin
				active_q <= (limit_q != 32'd0);
			end else if (answer_go) begin
				active_q <= !cmd.occupied && (trav < limit_q);
			end
			if ((ctl_q == ST_SETUP && su_done) || answer_go) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Ray state and result payload.
	always_ff @(posedge clk) begin
		if (start_go) begin
			cell_q[0]  <= cell_in(cmd.origin_x);
			cell_q[1]  <= cell_in(cmd.origin_y);
			cell_q[2]  <= cell_in(cmd.origin_z);
			start_q[0] <= cell_in(cmd.origin_x);
			start_q[1] <= cell_in(cmd.origin_y);
			start_q[2] <= cell_in(cmd.origin_z);
			for (int a = 0; a < 3; a++) begin
				sign_q[a] <= dir_w[a] < 0;
			end
			limit_q <= cmd.max_distance;
			last_q  <= AXIS_NONE;
		end else if (ctl_q == ST_SETUP && su_done) begin
			bnd_q <= su_bnd;
			rsp_q <= rsp_first;
		end else if (answer_go) begin
			if (cmd.occupied) begin
				rsp_q <= rsp_hit;
			end else begin
				cell_q     <= cell_step;
				bnd_q[sel] <= bnd_sum[32] ? LEN_SAT : bnd_sum[31:0];
				last_q     <= sel;
				rsp_q      <= rsp_step;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: hdl/vrds_checker.sv
// ----------------------------------------------------------------------------
// vrds_checker
// Port-level checks on the result channel of the voxel ray stepper.
// ----------------------------------------------------------------------------
`include "voxel_ray_dda_stepper_assert.svh"

module vrds_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input vrds_pkg::rsp_t rsp
);
	import vrds_pkg::*;

	// A stalled result stays in place unchanged.
	`VRDS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result changed")

	// Only the three defined result kinds appear.
	`VRDS_ASSERT_NOW(a_kind_legal, rsp_valid, rsp.kind == KIND_QUERY || rsp.kind == KIND_HIT || rsp.kind == KIND_MISS, "illegal result kind")

	// A miss carries no voxel and no backtrack voxel.
	`VRDS_ASSERT_NOW(a_miss_clean, rsp_valid && rsp.kind == KIND_MISS, rsp.voxel_x == 16'd0 && rsp.voxel_y == 16'd0 && rsp.voxel_z == 16'd0 && !rsp.back_valid, "miss with voxel data")

	// Backtrack data comes only with a hit.
	`VRDS_ASSERT_NOW(a_back_hit, rsp_valid && rsp.back_valid, rsp.kind == KIND_HIT, "backtrack without hit")

endmodule

bind voxel_ray_dda_stepper vrds_checker u_vrds_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the voxel ray stepper: drives start and answer
// requests, predicts every query, hit and miss result, and compares them.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import vrds_pkg::*;

	localparam int N_RANDOM  = 1100;
	localparam int WDOG_MAX  = 4000;
	localparam int TAIL_WAIT = 300;

	// Tracks one ray in flight and holds the queue of predicted results.
	class ray_scoreboard;
		logic [15:0] cur_cell [3];
		logic [15:0] start_cell [3];
		bit          step_neg [3];
		logic [31:0] bound [3];
		logic [31:0] unit [3];
		logic [31:0] travelled;
		logic [31:0] limit;
		logic [1:0]  last_axis;
		bit          ray_live;
		rsp_t        pending [$];
		int          errors;
		int          n_rays;
		int          n_hits;
		int          n_miss;
		int          n_query;
		int          n_back;

		function new();
			for (int a = 0; a < 3; a++) begin
				cur_cell[a] = '0;
				start_cell[a] = '0;
				step_neg[a] = 0;
				bound[a] = '0;
				unit[a] = '0;
			end
			travelled = '0;
			limit = '0;
			last_axis = AXIS_NONE;
			ray_live = 0;
			errors = 0;
		endfunction

		// Integer square root, one result bit per pair of input bits.
		function longint unsigned root64(longint unsigned n);
			longint unsigned r;
			longint unsigned b;
			r = 0;
			b = 64'd1 << 62;
			while (b > n)
				b >>= 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function rsp_t shape(logic [1:0] kind, bit with_cell, bit with_back);
			rsp_t r;
			logic [15:0] bk [3];
			r = '0;
			r.kind = kind;
			if (with_cell) begin
				r.voxel_x = cur_cell[0];
				r.voxel_y = cur_cell[1];
				r.voxel_z = cur_cell[2];
			end
			if (with_back) begin
				for (int a = 0; a < 3; a++) begin
					bk[a] = cur_cell[a];
					if (a == last_axis)
						bk[a] = step_neg[a] ? cur_cell[a] + 16'd1 : cur_cell[a] - 16'd1;
				end
				r.back_x = bk[0];
				r.back_y = bk[1];
				r.back_z = bk[2];
				r.back_valid = 1'b1;
			end
			return r;
		endfunction

		// Advances the prediction by one accepted request.
		function void note_request(cmd_t c);
			longint signed   d [3];
			logic [31:0]     org [3];
			longint unsigned sq;
			longint unsigned len;
			longint unsigned mag;
			longint unsigned u;
			longint unsigned b;
			int              ax;
			bit              moved;
			d[0] = c.dir_x;
			d[1] = c.dir_y;
			d[2] = c.dir_z;
			org[0] = c.origin_x;
			org[1] = c.origin_y;
			org[2] = c.origin_z;
			if (c.op == OP_START) begin
				n_rays++;
				sq = 0;
				for (int a = 0; a < 3; a++)
					sq += longint'(d[a] * d[a]);
				len = root64(sq << 32);
				for (int a = 0; a < 3; a++) begin
					mag = (d[a] < 0) ? -d[a] : d[a];
					if (mag == 0) begin
						u = 64'hFFFF_FFFF;
					end else begin
						u = len / mag;
						if (u > 64'hFFFF_FFFF)
							u = 64'hFFFF_FFFF;
					end
					unit[a] = u[31:0];
					step_neg[a] = d[a] < 0;
					b = (d[a] < 0) ? org[a][15:0] : (64'h1_0000 - org[a][15:0]);
					b = (b * u) >> 16;
					bound[a] = (b > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : b[31:0];
					cur_cell[a] = org[a][31:16];
					start_cell[a] = cur_cell[a];
				end
				limit = c.max_distance;
				travelled = '0;
				last_axis = AXIS_NONE;
				ray_live = travelled < limit;
				pending.push_back(ray_live ? shape(KIND_QUERY, 1, 0) : shape(KIND_MISS, 0, 0));
				return;
			end
			if (!ray_live)
				return;
			if (c.occupied) begin
				moved = last_axis != AXIS_NONE && (cur_cell[0] != start_cell[0] ||
					cur_cell[1] != start_cell[1] || cur_cell[2] != start_cell[2]);
				ray_live = 0;
				pending.push_back(shape(KIND_HIT, 1, moved));
				return;
			end
			// Step along the nearest boundary; ties fall through to z.
			if (bound[0] < bound[1] && bound[0] < bound[2])
				ax = 0;
			else if (bound[1] < bound[0] && bound[1] < bound[2])
				ax = 1;
			else
				ax = 2;
			cur_cell[ax] = step_neg[ax] ? cur_cell[ax] - 16'd1 : cur_cell[ax] + 16'd1;
			travelled = bound[ax];
			b = longint'(bound[ax]) + unit[ax];
			bound[ax] = (b > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : b[31:0];
			last_axis = ax[1:0];
			if (travelled < limit) begin
				pending.push_back(shape(KIND_QUERY, 1, 0));
			end else begin
				ray_live = 0;
				pending.push_back(shape(KIND_MISS, 0, 0));
			end
		endfunction

		// Compares one accepted result with the oldest prediction.
		function void check_result(rsp_t r);
			rsp_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %p", r);
				return;
			end
			e = pending.pop_front();
			case (e.kind)
				KIND_QUERY: n_query++;
				KIND_HIT:   n_hits++;
				default:    n_miss++;
			endcase
			if (e.back_valid)
				n_back++;
			if (r.kind !== e.kind || r.voxel_x !== e.voxel_x || r.voxel_y !== e.voxel_y ||
					r.voxel_z !== e.voxel_z || r.back_x !== e.back_x ||
					r.back_y !== e.back_y || r.back_z !== e.back_z ||
					r.back_valid !== e.back_valid) begin
				errors++;
				if (errors <= 10)
					$display("result mismatch: expected %p, got %p", e, r);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	ray_scoreboard sb;
	bit            idling_on;
	int            quiet_cycles;

	voxel_ray_dda_stepper dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Result side: random stall, checking of every accepted result.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_result(rsp);
		rsp_stall <= idling_on && ($urandom_range(0, 99) < 7);
	end

	// Watchdog on cycles with no handshake on either channel.
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_MAX) begin
			$display("watchdog expired with %0d results outstanding", sb.pending.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// Presents one request and holds it until taken.
	task automatic send(cmd_t c);
		cmd <= c;
		cmd_valid <= 1'b1;
		do
			@(posedge clk);
		while (cmd_stall);
		sb.note_request(c);
		if (idling_on && $urandom_range(0, 99) < 7) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 4))
				@(posedge clk);
		end
	endtask

	function automatic cmd_t start_req(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
			logic [15:0] dx, logic [15:0] dy, logic [15:0] dz, logic [31:0] lim);
		cmd_t c;
		c = '0;
		c.op = OP_START;
		c.origin_x = ox;
		c.origin_y = oy;
		c.origin_z = oz;
		c.dir_x = dx;
		c.dir_y = dy;
		c.dir_z = dz;
		c.max_distance = lim;
		c.occupied = 1'($urandom_range(0, 1));
		return c;
	endfunction

	// Answer request with random content in the fields it does not use.
	function automatic cmd_t answer_req(bit occ);
		cmd_t c;
		c = '0;
		c.origin_x = $urandom;
		c.origin_y = $urandom;
		c.origin_z = $urandom;
		c.dir_x = 16'($urandom);
		c.dir_y = 16'($urandom);
		c.dir_z = 16'($urandom);
		c.max_distance = $urandom;
		c.op = OP_ANSWER;
		c.occupied = occ;
		return c;
	endfunction

	function automatic logic [15:0] rand_dir();
		case ($urandom_range(0, 5))
			0:       return 16'sh0000;
			1:       return 16'sh8000;
			2:       return 16'sh7FFF;
			3:       return 16'($urandom_range(0, 3) - 2);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand_origin();
		case ($urandom_range(0, 3))
			0:       return $urandom;
			1:       return {($urandom_range(0, 1) ? 16'h7FFF : 16'h8000), 16'($urandom)};
			default: return {16'($urandom_range(0, 15) - 8), 16'($urandom)};
		endcase
	endfunction

	function automatic logic [31:0] rand_limit();
		case ($urandom_range(0, 9))
			0:       return 32'd0;
			1:       return $urandom;
			2:       return $urandom_range(1, 32'h0000_FFFF);
			default: return $urandom_range(1, 32'h0018_0000);
		endcase
	endfunction

	// Answers the current ray, mostly as empty space, until it ends or max_ans answers are sent.
	task automatic walk_ray(int max_ans, int hit_odds);
		int n;
		n = 0;
		while (sb.ray_live && n < max_ans) begin
			send(answer_req($urandom_range(0, hit_odds - 1) == 0));
			n++;
		end
	endtask

	initial begin
		int items;
		int ans_cap;
		sb = new();
		idling_on = 1'b0;
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		cmd <= '0;
		rsp_stall <= 1'b0;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests: stray answer, zero limit, zero direction, extremes.
		send(answer_req(1'b0));
		send(start_req(32'h0001_8000, 32'h0, 32'h0, 16'sh7FFF, 16'sh0, 16'sh0, 32'd0));
		send(start_req(32'h0000_4000, 32'h0000_4000, 32'h0000_4000, 16'h0, 16'h0, 16'h0,
			32'hFFFF_FFFF));
		send(answer_req(1'b0));
		send(answer_req(1'b1));
		send(start_req(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 16'sh8000, 16'sh7FFF,
			16'sh8000, 32'h0004_0000));
		send(answer_req(1'b1));
		send(start_req(32'h7FFF_C000, 32'h8000_4000, 32'h0000_0000, 16'sh4000, 16'shC000,
			16'sh4000, 32'h0008_0000));
		walk_ray(6, 1000);
		send(answer_req(1'b1));
		send(start_req(32'hFFFF_FFFF, 32'h0, 32'h0, 16'sh8000, 16'sh0, 16'sh0, 32'h0003_0000));
		walk_ray(20, 1000);
		send(answer_req(1'b1));
		send(start_req(32'h0, 32'h0, 32'h0, 16'sh0001, 16'sh0001, 16'sh0001, 32'h0002_0000));
		send(answer_req(1'b0));
		send(start_req(32'h1234_5678, 32'hEDCB_A987, 32'h0, 16'sh0, 16'sh0, 16'shFFFF,
			32'h0000_0001));
		walk_ray(4, 1000);

		// Random rays with random content, plus stray answers and restarts.
		items = 0;
		while (items < N_RANDOM) begin
			idling_on = !(items > 400 && items < 650);
			if ($urandom_range(0, 99) < 5) begin
				if (sb.ray_live)
					items++;
				send(answer_req($urandom_range(0, 1)));
			end else begin
				send(start_req(rand_origin(), rand_origin(), rand_origin(), rand_dir(),
					rand_dir(), rand_dir(), rand_limit()));
				items++;
				ans_cap = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 60;
				while (sb.ray_live && ans_cap > 0) begin
					send(answer_req($urandom_range(0, 11) == 0));
					items++;
					ans_cap--;
				end
			end
		end
		cmd_valid <= 1'b0;

		// Drain, then allow a full setup time for anything still in flight.
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT)
			@(posedge clk);

		$display("covered %0d rays: %0d queries, %0d hits (%0d with backtrack), %0d misses",
			sb.n_rays, sb.n_query, sb.n_hits, sb.n_back, sb.n_miss);
		$display("random directions, origins near wrap, zero and full limits, stray answers");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d errors, %0d results never seen", sb.errors, sb.pending.size());
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
